// ===== hdl/compacting_address_keyed_table_defines.svh =====
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef COMPACTING_ADDRESS_KEYED_TABLE_DEFINES_SVH
`define COMPACTING_ADDRESS_KEYED_TABLE_DEFINES_SVH

// Same-cycle implication.
`define CAKT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cakt check failed");

// Next-cycle implication.
`define CAKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cakt check failed");

`endif

// ===== hdl/cakt_pkg.sv =====
package cakt_pkg;

  localparam int unsigned FIELD_BITS = 48;
  localparam int unsigned CNT_OUT_BITS = 7;
  localparam int unsigned S_DATA_BITS = 96;
  localparam int unsigned M_DATA_BITS = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic active;
    logic write_en;
    logic shift_en;
  } cell_ctl_t;

endpackage

// ===== hdl/cakt_cell.sv =====
module cakt_cell #(
  parameter int unsigned KW = 48,
  parameter int unsigned PW = 48
) (
  input  logic               clk,
  input  cakt_pkg::cell_ctl_t ctl,
  input  logic [KW-1:0]      cmp_key,
  input  logic [PW-1:0]      new_payload,
  input  logic [KW-1:0]      nxt_key,
  input  logic [PW-1:0]      nxt_payload,
  input  logic               hit_in,
  input  logic [PW-1:0]      found_in,
  output logic [KW-1:0]      key,
  output logic [PW-1:0]      payload,
  output logic               hit_out,
  output logic [PW-1:0]      found_out,
  output logic               first
);

  logic match;

  assign match     = ctl.active && (key == cmp_key);
  assign first     = match && !hit_in;
  assign hit_out   = hit_in || match;
  assign found_out = found_in | (first ? payload : '0);

  // remove: this cell and every later one take their neighbor's record
  always_ff @(posedge clk) begin
    if (ctl.write_en) begin
      key     <= cmp_key;
      payload <= new_payload;
    end else if (ctl.shift_en && hit_out) begin
      key     <= nxt_key;
      payload <= nxt_payload;
    end
  end

endmodule

// ===== hdl/compacting_address_keyed_table.sv =====
// Compacting address-keyed table.
// Input stream s_*: one command word per transfer; s_tuser is the command
// (insert, remove, search, clear), s_tdata carries key and payload.
// Output stream m_*: exactly one result word per command; m_tuser is the
// status, m_tdata carries found payload, entries used and entries free.
// Config channel cfg_*: writes the entry limit; write only while idle.
// Each record sits in one cell of a row; all cells compare the key at once,
// a hit ripples down the row to pick the first match, and on remove the hit
// cell and every cell past it load their right neighbor in the same cycle.
// The result is registered in the execute state, once the output is free.
// A new command is accepted only after the previous one has executed.
// A stalled output holds its word; the next command is still accepted and
// executes as soon as the output register frees up.
// Reset empties the table and sets the entry limit to 64; record contents
// are not cleared.
`include "compacting_address_keyed_table_defines.svh"

module compacting_address_keyed_table #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned KEY_BITS     = 48,
  parameter int unsigned PAYLOAD_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [47:0] key_address, [95:48] entry_payload
  input  logic [cakt_pkg::S_DATA_BITS-1:0] s_tdata,
  // [1:0] command
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [47:0] found_payload, [54:48] entries_used, [61:55] entries_free, [63:62] zero
  output logic [cakt_pkg::M_DATA_BITS-1:0] m_tdata,
  // [1:0] status
  output logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int unsigned FB = cakt_pkg::FIELD_BITS;
  localparam int unsigned OB = cakt_pkg::CNT_OUT_BITS;
  localparam int unsigned KW = (KEY_BITS < FB) ? KEY_BITS : FB;
  localparam int unsigned PW = (PAYLOAD_BITS < FB) ? PAYLOAD_BITS : FB;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW = (CW > OB) ? CW : OB;

  cakt_pkg::state_t  state, state_next;
  cakt_pkg::cmd_t    cmd_q;
  logic [KW-1:0]     key_q;
  logic [PW-1:0]     pay_q;
  logic [CW-1:0]     count, count_next;
  logic [OB-1:0]     entry_limit;

  logic              s_fire, exec_go, out_free;
  logic [LW-1:0]     lim, cnt_ext, cnt_next_ext, free_cnt;
  logic              full, insert_ok;
  cakt_pkg::status_t status;
  logic [FB-1:0]     found_w;

  logic [KW-1:0]     keys  [TABLE_DEPTH];
  logic [PW-1:0]     pays  [TABLE_DEPTH];
  logic [TABLE_DEPTH:0] hit;
  logic [PW-1:0]     fnd   [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] first_vec;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == cakt_pkg::S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign lim = (LW'(entry_limit) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(entry_limit);
  assign cnt_ext   = LW'(count);
  assign full      = cnt_ext >= lim;
  assign insert_ok = (cmd_q == cakt_pkg::CMD_INSERT) && !full;

  assign hit[0] = 1'b0;
  assign fnd[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cakt_pkg::cell_ctl_t ctl;
    logic [KW-1:0] nk;
    logic [PW-1:0] np;

    assign ctl.active   = CW'(i) < count;
    assign ctl.write_en = exec_go && insert_ok && (count == CW'(i));
    assign ctl.shift_en = exec_go && (cmd_q == cakt_pkg::CMD_REMOVE);

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nk = keys[i];
      assign np = pays[i];
    end else begin : g_mid
      assign nk = keys[i+1];
      assign np = pays[i+1];
    end

    cakt_cell #(.KW(KW), .PW(PW)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cmp_key    (key_q),
      .new_payload(pay_q),
      .nxt_key    (nk),
      .nxt_payload(np),
      .hit_in     (hit[i]),
      .found_in   (fnd[i]),
      .key        (keys[i]),
      .payload    (pays[i]),
      .hit_out    (hit[i+1]),
      .found_out  (fnd[i+1]),
      .first      (first_vec[i])
    );
  end

  always_comb begin
    count_next = count;
    status     = cakt_pkg::ST_OK;
    found_w    = '0;
    case (cmd_q)
      cakt_pkg::CMD_INSERT: begin
        if (full) status = cakt_pkg::ST_FULL;
        else count_next = count + CW'(1);
      end
      cakt_pkg::CMD_REMOVE: begin
        if (hit[TABLE_DEPTH]) count_next = count - CW'(1);
        else status = cakt_pkg::ST_NOT_FOUND;
      end
      cakt_pkg::CMD_SEARCH: begin
        if (hit[TABLE_DEPTH]) found_w = FB'(fnd[TABLE_DEPTH]);
        else status = cakt_pkg::ST_NOT_FOUND;
      end
      cakt_pkg::CMD_CLEAR: count_next = '0;
      default: count_next = count;
    endcase
  end

  assign cnt_next_ext = LW'(count_next);
  assign free_cnt     = (lim > cnt_next_ext) ? lim - cnt_next_ext : '0;

  always_comb begin
    state_next = state;
    case (state)
      cakt_pkg::S_IDLE: if (s_fire) state_next = cakt_pkg::S_EXEC;
      cakt_pkg::S_EXEC: if (out_free) state_next = cakt_pkg::S_IDLE;
      default: state_next = cakt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      cakt_pkg::S_EXEC: exec_go = out_free;
      default: exec_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cakt_pkg::S_IDLE;
      count       <= '0;
      entry_limit <= OB'(64);
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) entry_limit <= cfg_data;
      if (exec_go) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      cmd_q <= cakt_pkg::cmd_t'(s_tuser);
      key_q <= KW'(s_tdata[FB-1:0]);
      pay_q <= PW'(s_tdata[2*FB-1:FB]);
    end
    if (exec_go) begin
      m_tuser <= status;
      m_tdata <= {2'b00, OB'(free_cnt), OB'(count_next), found_w};
    end
  end

  `CAKT_ASSERT_NOW(a_count_bound, 1'b1, LW'(count) <= LW'(TABLE_DEPTH))
  `CAKT_ASSERT_NOW(a_first_unique, 1'b1, $onehot0(first_vec))
  `CAKT_ASSERT_NEXT(a_accept_blocks, s_fire, !s_tready)
  `CAKT_ASSERT_NEXT(a_clear_empties, exec_go && (cmd_q == cakt_pkg::CMD_CLEAR),
                    count == '0 && m_tvalid)

endmodule
